/* sv/spa_pkg.sv */
// spa_pkg: shared types and codes for the segregated pool allocator
// holds request and status codes plus the controller/datapath command and status structs
// no dependencies
package spa_pkg;

    // request type codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_BIG  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // width of arena addresses as seen on the ports
    localparam int ADDR_W = 16;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;      // latch the accepted request beat
        logic mul_size;     // reciprocal multiply of size - 1
        logic classify;     // pick pool, handle special cases and bump path
        logic mul_addr;     // reciprocal multiply of the block address
        logic qload;        // load granule quotient into the reducer
        logic reduce_step;  // one conditional subtract of the reducer
        logic mem_write;    // push a freed block onto its chain
        logic mem_read;     // read the link of the chain head
        logic pop;          // pop the chain head using the read link
        logic load_out;     // move the result into the output register
    } spa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic special;      // zero size or too large
        logic chain;        // free request or non-empty chain
        logic is_free;      // captured request is a free
        logic red_last;     // reducer is on its last step
        logic out_busy;     // output register holds a beat that is not taken
    } spa_stat_t;

endpackage

/* sv/spa_ctrl.sv */
// spa_ctrl: sequencing state machine of the segregated pool allocator
// depends on spa_pkg for the command and status structs
module spa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  spa_pkg::spa_stat_t  stat,
    output spa_pkg::spa_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULS  = 4'd1;
    localparam logic [3:0] S_CLASS = 4'd2;
    localparam logic [3:0] S_MULA  = 4'd3;
    localparam logic [3:0] S_QLD   = 4'd4;
    localparam logic [3:0] S_RED   = 4'd5;
    localparam logic [3:0] S_MEM   = 4'd6;
    localparam logic [3:0] S_POP   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MULS;
                end
            end
            S_MULS:
            begin
                cmd.mul_size = 1'b1;
                state_next   = S_CLASS;
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                if (!stat.special && stat.chain)
                begin
                    state_next = S_MULA;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MULA:
            begin
                cmd.mul_addr = 1'b1;
                state_next   = S_QLD;
            end
            S_QLD:
            begin
                cmd.qload  = 1'b1;
                state_next = S_RED;
            end
            S_RED:
            begin
                cmd.reduce_step = 1'b1;
                if (stat.red_last)
                begin
                    state_next = S_MEM;
                end
            end
            S_MEM:
            begin
                if (stat.is_free)
                begin
                    cmd.mem_write = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = S_POP;
                end
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/spa_datapath.sv */
// spa_datapath: registers, shared reciprocal multiplier, granule reducer and link memory
// depends on spa_pkg for codes and the command and status structs
module spa_datapath #(
    parameter int POOL_COUNT    = 16,
    parameter int ARENA_BYTES   = 65536,
    parameter int GRANULE_BYTES = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  spa_pkg::spa_cmd_t            cmd,
    output spa_pkg::spa_stat_t           stat,
    input  logic                         req_type,
    input  logic [15:0]                  size_bytes,
    input  logic [15:0]                  free_address,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [15:0]                  block_address,
    output logic [1:0]                   status,
    output logic                         recycled,
    output logic [3:0]                   pool_index
);

    localparam int AW    = spa_pkg::ADDR_W;
    localparam int DEPTH = ARENA_BYTES / GRANULE_BYTES;
    localparam int GW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PIW   = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int QMAX  = 65535 / GRANULE_BYTES;
    localparam int QW    = $clog2(QMAX + 1);
    localparam int SH    = AW + $clog2(GRANULE_BYTES);
    localparam int MW    = AW + 2;
    localparam int PRW   = AW + MW;
    localparam longint MULT_L = ((64'd1 << SH) + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam logic [MW-1:0] MULT = MW'(MULT_L);
    localparam int BPW   = $clog2(ARENA_BYTES + 1);
    localparam int BLW   = $clog2(GRANULE_BYTES * POOL_COUNT + 1);

    // steps of the granule modulo reduction
    function automatic int red_steps_f();
        int n;
        n = 1;
        for (int i = 1; i < 24; i++)
        begin
            if ((longint'(DEPTH) << i) <= longint'(QMAX))
            begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    localparam int RED_STEPS = red_steps_f();
    localparam int KW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    // captured request
    logic                  req_type_reg;
    logic [AW-1:0]         size_reg;
    logic [AW-1:0]         faddr_reg;

    // multiplier and reducer
    logic [PRW-1:0]        prod_reg;
    logic [AW-1:0]         mul_op;
    logic [QW-1:0]         rem_reg;
    logic [KW-1:0]         red_k_reg;
    logic [QW-1:0]         rem_next;
    logic [GW-1:0]         gran;

    // pool state
    logic [PIW-1:0]        pool_reg;
    logic [QW-1:0]         pool_full;
    logic [PIW-1:0]        pool_sel;
    logic                  zero_size;
    logic                  too_big;
    logic [AW-1:0]         head_reg [POOL_COUNT];
    logic [POOL_COUNT-1:0] nonempty_reg;
    logic [BPW-1:0]        bump_reg;
    logic [BLW-1:0]        block_size;
    logic [BPW:0]          bump_sum;
    logic                  exhausted;

    // link memory
    logic [AW:0]           link_mem [DEPTH];
    logic [AW:0]           link_rdata_reg;

    // pending result
    logic [AW-1:0]         res_addr_reg;
    logic [1:0]            res_status_reg;
    logic                  res_recycled_reg;
    logic [3:0]            res_pool_reg;

    // output register
    logic                  out_valid_reg;
    logic [AW-1:0]         out_addr_reg;
    logic [1:0]            out_status_reg;
    logic                  out_recycled_reg;
    logic [3:0]            out_pool_reg;

    // pool decode from the size quotient
    assign zero_size  = (size_reg == '0);
    assign pool_full  = QW'(prod_reg >> SH);
    assign too_big    = (pool_full >= QW'(POOL_COUNT));
    assign pool_sel   = PIW'(pool_full);
    assign block_size = BLW'(GRANULE_BYTES) * (BLW'(pool_sel) + BLW'(1));
    assign bump_sum   = (BPW + 1)'(bump_reg) + (BPW + 1)'(block_size);
    assign exhausted  = (bump_sum > (BPW + 1)'(ARENA_BYTES));

    // multiplier operand select
    assign mul_op = cmd.mul_addr
                  ? ((req_type_reg == spa_pkg::REQ_FREE) ? faddr_reg : head_reg[pool_reg])
                  : (size_reg - AW'(1));

    // one conditional subtract of the reducer
    always_comb
    begin
        longint wide;
        wide     = longint'(DEPTH) << red_k_reg;
        rem_next = rem_reg;
        if (longint'(rem_reg) >= wide)
        begin
            rem_next = rem_reg - QW'(wide);
        end
    end

    assign gran = GW'(rem_reg);

    // status to the controller
    assign stat.special  = zero_size || too_big;
    assign stat.chain    = (req_type_reg == spa_pkg::REQ_FREE) || nonempty_reg[pool_sel];
    assign stat.is_free  = (req_type_reg == spa_pkg::REQ_FREE);
    assign stat.red_last = (red_k_reg == '0);
    assign stat.out_busy = out_valid_reg && !rsp_ready;

    // request capture, multiplier and reducer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            size_reg     <= size_bytes;
            faddr_reg    <= free_address;
        end
        if (cmd.mul_size || cmd.mul_addr)
        begin
            prod_reg <= PRW'(mul_op) * PRW'(MULT);
        end
        if (cmd.qload)
        begin
            rem_reg   <= QW'(prod_reg >> SH);
            red_k_reg <= KW'(RED_STEPS - 1);
        end
        else if (cmd.reduce_step)
        begin
            rem_reg <= rem_next;
            if (red_k_reg != '0)
            begin
                red_k_reg <= red_k_reg - KW'(1);
            end
        end
        if (cmd.classify)
        begin
            pool_reg <= pool_sel;
        end
    end

    // pending result fields
    always_ff @(posedge clk)
    begin
        if (cmd.classify)
        begin
            res_addr_reg     <= '0;
            res_recycled_reg <= 1'b0;
            if (zero_size)
            begin
                res_status_reg <= spa_pkg::ST_ZERO;
                res_pool_reg   <= '0;
            end
            else if (too_big)
            begin
                res_status_reg <= spa_pkg::ST_BIG;
                res_pool_reg   <= '0;
            end
            else
            begin
                res_pool_reg <= 4'(pool_sel);
                if (exhausted)
                begin
                    res_status_reg <= spa_pkg::ST_FULL;
                end
                else
                begin
                    res_status_reg <= spa_pkg::ST_DONE;
                    res_addr_reg   <= AW'(bump_reg);
                end
            end
        end
        else if (cmd.mem_write)
        begin
            res_addr_reg     <= '0;
            res_status_reg   <= spa_pkg::ST_DONE;
            res_recycled_reg <= 1'b0;
        end
        else if (cmd.pop)
        begin
            res_addr_reg     <= head_reg[pool_reg];
            res_status_reg   <= spa_pkg::ST_DONE;
            res_recycled_reg <= 1'b1;
        end
    end

    // chain heads
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            head_reg[pool_reg] <= faddr_reg;
        end
        else if (cmd.pop)
        begin
            head_reg[pool_reg] <= link_rdata_reg[AW-1:0];
        end
    end

    // chain occupancy and bump pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '0;
            bump_reg     <= '0;
        end
        else
        begin
            if (cmd.mem_write)
            begin
                nonempty_reg[pool_reg] <= 1'b1;
            end
            else if (cmd.pop)
            begin
                nonempty_reg[pool_reg] <= link_rdata_reg[AW];
            end
            if (cmd.classify && !zero_size && !too_big
                && (req_type_reg == spa_pkg::REQ_ALLOC) && !nonempty_reg[pool_sel]
                && !exhausted)
            begin
                bump_reg <= BPW'(bump_sum);
            end
        end
    end

    // link memory write
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            link_mem[gran] <= {nonempty_reg[pool_reg], head_reg[pool_reg]};
        end
    end

    // link memory registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            link_rdata_reg <= link_mem[gran];
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_addr_reg     <= res_addr_reg;
            out_status_reg   <= res_status_reg;
            out_recycled_reg <= res_recycled_reg;
            out_pool_reg     <= res_pool_reg;
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign block_address = out_addr_reg;
    assign status        = out_status_reg;
    assign recycled      = out_recycled_reg;
    assign pool_index    = out_pool_reg;

endmodule

/* sv/segregated_pool_allocator.sv */
// segregated_pool_allocator: one request beat in, one result beat out per request
// sequence: capture, size multiply and classify, then the output load for zero size, too large
// and bump allocations; a free adds the address multiply, quotient load, granule reduction steps
// (1 by default) and link write, a chain pop the link read and pop; a new request is taken only
// in idle, once the last has reached the output register, which frees the input side
// reset: chain occupancy, bump pointer and control clear at once; no clearing pass
module segregated_pool_allocator #(
    parameter int POOL_COUNT    = 16,
    parameter int ARENA_BYTES   = 65536,
    parameter int GRANULE_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        req_type,
    input  logic [15:0] size_bytes,
    input  logic [15:0] free_address,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [15:0] block_address,
    output logic [1:0]  status,
    output logic        recycled,
    output logic [3:0]  pool_index
);

    spa_pkg::spa_cmd_t  cmd;
    spa_pkg::spa_stat_t stat;

    // sequencer
    spa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath and link memory
    spa_datapath #(
        .POOL_COUNT    (POOL_COUNT),
        .ARENA_BYTES   (ARENA_BYTES),
        .GRANULE_BYTES (GRANULE_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .size_bytes    (size_bytes),
        .free_address  (free_address),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .block_address (block_address),
        .status        (status),
        .recycled      (recycled),
        .pool_index    (pool_index)
    );

endmodule

/* dv/segregated_pool_allocator_tb.sv */
// segregated_pool_allocator_tb: self-checking testbench for the segregated pool allocator
// drives request beats, predicts every response with its own copy of the pools and arena
// depends on spa_pkg and segregated_pool_allocator
module segregated_pool_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOLS = 16;
    localparam int ARENA = 65536;
    localparam int GRAN  = 8;
    localparam int LINKS = ARENA / GRAN;

    typedef struct packed {
        logic        req_type;
        logic [15:0] size;
        logic [15:0] faddr;
    } req_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
        logic        recycled;
        logic [3:0]  pool;
    } rsp_t;

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t want;
    } row_t;

    typedef struct {
        logic [15:0] addr;
        int          pool;
    } held_block_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic        req_type;
    logic [15:0] size_bytes;
    logic [15:0] free_address;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [15:0] block_address;
    logic [1:0]  status;
    logic        recycled;
    logic [3:0]  pool_index;

    // mirror of the allocator state
    logic [15:0] head_addr [POOLS];
    logic        head_live [POOLS];
    logic [16:0] chain_link [LINKS];
    int unsigned bump_next;

    rsp_t        due_responses [$];
    held_block_t held_blocks [$];
    int          fault_count;
    int          responses_seen;

    // directed beats: typed responses only where they are plain to see
    row_t directed [25] = '{
        '{'{spa_pkg::REQ_ALLOC, 16'd0, 16'hFFFF}, 1'b1,
          '{16'd0, spa_pkg::ST_ZERO, 1'b0, 4'd0}},
        '{'{spa_pkg::REQ_FREE, 16'd0, 16'h0000}, 1'b1,
          '{16'd0, spa_pkg::ST_ZERO, 1'b0, 4'd0}},
        '{'{spa_pkg::REQ_ALLOC, 16'd129, 16'h0000}, 1'b1,
          '{16'd0, spa_pkg::ST_BIG, 1'b0, 4'd0}},
        '{'{spa_pkg::REQ_ALLOC, 16'd65535, 16'hFFFF}, 1'b1,
          '{16'd0, spa_pkg::ST_BIG, 1'b0, 4'd0}},
        '{'{spa_pkg::REQ_FREE, 16'd65535, 16'h1234}, 1'b1,
          '{16'd0, spa_pkg::ST_BIG, 1'b0, 4'd0}},
        '{'{spa_pkg::REQ_ALLOC, 16'd1, 16'h0000}, 1'b1,
          '{16'd0, spa_pkg::ST_DONE, 1'b0, 4'd0}},
        '{'{spa_pkg::REQ_ALLOC, 16'd128, 16'h0000}, 1'b1,
          '{16'd8, spa_pkg::ST_DONE, 1'b0, 4'd15}},
        '{'{spa_pkg::REQ_ALLOC, 16'd8, 16'h0000}, 1'b0, '0},
        '{'{spa_pkg::REQ_ALLOC, 16'd9, 16'h0000}, 1'b0, '0},
        '{'{spa_pkg::REQ_FREE, 16'd8, 16'h0000}, 1'b1,
          '{16'd0, spa_pkg::ST_DONE, 1'b0, 4'd0}},
        '{'{spa_pkg::REQ_FREE, 16'd1, 16'd136}, 1'b1,
          '{16'd0, spa_pkg::ST_DONE, 1'b0, 4'd0}},
        '{'{spa_pkg::REQ_ALLOC, 16'd5, 16'h0000}, 1'b0, '0},
        '{'{spa_pkg::REQ_ALLOC, 16'd5, 16'h0000}, 1'b0, '0},
        '{'{spa_pkg::REQ_ALLOC, 16'd5, 16'h0000}, 1'b0, '0},
        '{'{spa_pkg::REQ_FREE, 16'd128, 16'hFFFF}, 1'b1,
          '{16'd0, spa_pkg::ST_DONE, 1'b0, 4'd15}},
        '{'{spa_pkg::REQ_FREE, 16'd121, 16'h0003}, 1'b1,
          '{16'd0, spa_pkg::ST_DONE, 1'b0, 4'd15}},
        '{'{spa_pkg::REQ_ALLOC, 16'd128, 16'h0000}, 1'b0, '0},
        '{'{spa_pkg::REQ_ALLOC, 16'd128, 16'h0000}, 1'b0, '0},
        '{'{spa_pkg::REQ_ALLOC, 16'd128, 16'h0000}, 1'b0, '0},
        '{'{spa_pkg::REQ_FREE, 16'd64, 16'hFFF8}, 1'b1,
          '{16'd0, spa_pkg::ST_DONE, 1'b0, 4'd7}},
        '{'{spa_pkg::REQ_FREE, 16'd64, 16'hFFF8}, 1'b1,
          '{16'd0, spa_pkg::ST_DONE, 1'b0, 4'd7}},
        '{'{spa_pkg::REQ_ALLOC, 16'd57, 16'h0000}, 1'b0, '0},
        '{'{spa_pkg::REQ_ALLOC, 16'd64, 16'h0000}, 1'b0, '0},
        '{'{spa_pkg::REQ_ALLOC, 16'd64, 16'h0000}, 1'b0, '0},
        '{'{spa_pkg::REQ_ALLOC, 16'd16, 16'hFFFF}, 1'b0, '0}
    };

    segregated_pool_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .size_bytes    (size_bytes),
        .free_address  (free_address),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .block_address (block_address),
        .status        (status),
        .recycled      (recycled),
        .pool_index    (pool_index)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #15_000_000;
        $display("segregated_pool_allocator_tb: FAIL");
        $finish;
    end

    // response to one request, updating the mirrored pools and arena
    function automatic rsp_t serve_request(input req_t r);
        rsp_t        o;
        int unsigned pool;
        int unsigned blk;
        logic [16:0] link;
        o = '0;
        if (r.size == 16'd0)
        begin
            o.status = spa_pkg::ST_ZERO;
            return o;
        end
        pool = (int'(r.size) - 1) / GRAN;
        if (pool >= POOLS)
        begin
            o.status = spa_pkg::ST_BIG;
            return o;
        end
        blk    = GRAN * (pool + 1);
        o.pool = pool[3:0];
        o.status = spa_pkg::ST_DONE;
        // free: push onto the chain, old head becomes the link
        if (r.req_type == spa_pkg::REQ_FREE)
        begin
            chain_link[(int'(r.faddr) / GRAN) % LINKS] = {head_live[pool], head_addr[pool]};
            head_addr[pool] = r.faddr;
            head_live[pool] = 1'b1;
            return o;
        end
        // allocation from a non-empty chain pops the head
        if (head_live[pool])
        begin
            o.addr     = head_addr[pool];
            o.recycled = 1'b1;
            link = chain_link[(int'(head_addr[pool]) / GRAN) % LINKS];
            head_addr[pool] = link[15:0];
            head_live[pool] = link[16];
            return o;
        end
        // otherwise bump allocate, if the arena still holds the block
        if (bump_next + blk > ARENA)
        begin
            o.status = spa_pkg::ST_FULL;
            return o;
        end
        o.addr = bump_next[15:0];
        bump_next += blk;
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random request; the fill mix leans on large allocations to use up the arena
    function automatic req_t make_request(input bit filling);
        req_t        r;
        int          roll;
        int          idx;
        held_block_t b;
        r.req_type = 1'($urandom);
        r.size     = 16'($urandom);
        r.faddr    = 16'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 88 : 50))
        begin
            r.req_type = spa_pkg::REQ_ALLOC;
            if (filling && $urandom_range(0, 9) < 9)
                r.size = 16'($urandom_range(97, 128));
            else if ($urandom_range(0, 9) < 8)
                r.size = 16'($urandom_range(1, 128));
            else if ($urandom_range(0, 1) == 0)
                r.size = 16'd0;
        end
        else if (roll < (filling ? 97 : 90) && held_blocks.size() != 0)
        begin
            // free of a block that is actually held, now and then a double free
            idx = $urandom_range(0, held_blocks.size() - 1);
            b = held_blocks[idx];
            if ($urandom_range(0, 19) != 0)
                held_blocks.delete(idx);
            r.req_type = spa_pkg::REQ_FREE;
            r.faddr    = b.addr;
            r.size     = 16'(b.pool * GRAN + $urandom_range(1, GRAN));
        end
        return r;
    endfunction

    // offer one request beat and record its response once it is taken
    task automatic send_beat(input req_t r, input int gap, input bit typed, input rsp_t want);
        rsp_t        pred;
        held_block_t hb;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid    <= 1'b1;
        req_type     <= r.req_type;
        size_bytes   <= r.size;
        free_address <= r.faddr;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pred = serve_request(r);
        due_responses = {due_responses, (typed ? want : pred)};
        if (r.req_type == spa_pkg::REQ_ALLOC && pred.status == spa_pkg::ST_DONE)
        begin
            hb.addr = pred.addr;
            hb.pool = int'(pred.pool);
            held_blocks = {held_blocks, hb};
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
            fault_count++;
        end
    endtask

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            responses_seen++;
            if (due_responses.size() == 0)
            begin
                $display("%0t: response beat with nothing outstanding, block_address 0x%0h",
                         $time, block_address);
                fault_count++;
            end
            else
            begin
                check_field("block_address", due_responses[0].addr, block_address);
                check_field("status", due_responses[0].status, status);
                check_field("recycled", due_responses[0].recycled, recycled);
                check_field("pool_index", due_responses[0].pool, pool_index);
                void'(due_responses.pop_front());
            end
        end
    end

    // receiver: random stalls, ready bursts and two long hold-offs
    initial
    begin
        int k;
        int n;
        bit squeezed_early;
        bit squeezed_late;
        squeezed_early = 1'b0;
        squeezed_late  = 1'b0;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ((!squeezed_early && responses_seen >= 30) ||
                (!squeezed_late && responses_seen >= 700))
            begin
                if (responses_seen >= 700)
                    squeezed_late = 1'b1;
                squeezed_early = 1'b1;
                for (k = 0; k < 400; k++)
                    @(negedge clk) rsp_ready <= 1'b0;
            end
            n = pick_gap();
            repeat (n) @(negedge clk) rsp_ready <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 8);
            repeat (n) @(negedge clk) rsp_ready <= 1'b1;
        end
    end

    // stimulus and end of test
    initial
    begin
        int   i;
        int   gap;
        rsp_t none;
        none           = '0;
        fault_count    = 0;
        responses_seen = 0;
        bump_next      = 0;
        for (i = 0; i < POOLS; i++)
        begin
            head_addr[i] = '0;
            head_live[i] = 1'b0;
        end
        for (i = 0; i < LINKS; i++)
            chain_link[i] = '0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_type     = spa_pkg::REQ_ALLOC;
        size_bytes   = '0;
        free_address = '0;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (i = 0; i < 25; i++)
            send_beat(directed[i].req, pick_gap(), directed[i].typed, directed[i].want);

        // fill phase drives the arena toward exhaustion, churn phase mixes frees and pops
        for (i = 0; i < 1200; i++)
        begin
            gap = ((i % 200) < 40) ? 0 : pick_gap();
            send_beat(make_request(i < 800), gap, 1'b0, none);
        end
        @(negedge clk) req_valid <= 1'b0;

        while (due_responses.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fault_count == 0)
            $display("segregated_pool_allocator_tb: PASS");
        else
            $display("segregated_pool_allocator_tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/spa_pkg.sv
sv/spa_ctrl.sv
sv/spa_datapath.sv
sv/segregated_pool_allocator.sv
dv/segregated_pool_allocator_tb.sv
